FILE: src/eoe_pkg.sv
`timescale 1ns / 1ps

package eoe_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_W       = 32;
  localparam int CODE_W     = 43;
  localparam int LEN_W      = 6;

  // Bits of the input that take part in the code.
  localparam int VAL_W = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
  localparam int NB_W  = $clog2(VAL_W + 1);

  // Headers after the value itself: n <= VAL_W-1 shrinks to 1 in at most
  // four steps for any width up to 63 bits.
  localparam int NUM_SMALL = 4;
  localparam int OFF_W     = $clog2(2 + VAL_W + NUM_SMALL * NB_W);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [NB_W-1:0]  nb;
  } lzd_t;

  typedef struct packed {
    logic [VAL_W-1:0]                    value;
    logic                                big;
    logic [NUM_SMALL-1:0][NB_W-1:0]      sval;
    logic [NUM_SMALL-1:0]                suse;
    logic [NUM_SMALL-1:0][OFF_W-1:0]     soff;
    logic [OFF_W-1:0]                    total;
  } hdr_t;

  typedef struct packed {
    logic [CODE_W-1:0] codeword;
    logic [LEN_W-1:0]  code_length;
  } res_t;

endpackage

FILE: src/elias_omega_encoder.sv
`timescale 1ns / 1ps

// Elias omega encoder. One unsigned value goes in per transfer and one codeword
// comes out, right-aligned with the first bit to send at code_length_o-1; values
// 0 and 1 both give the single bit 0. The datapath is three register stages
// (leading-one detect, header chain, bit packing), and a new value is taken every
// cycle while the output is not stalled.
// Each stage advances when it is empty or the stage after it moves, so an
// output stall backs up through the stages without loss.

module elias_omega_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [eoe_pkg::IN_W-1:0]    value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [eoe_pkg::CODE_W-1:0]  codeword_o,
  output logic [eoe_pkg::LEN_W-1:0]   code_length_o
);
  import eoe_pkg::*;

  logic  v1, v2, v3;
  logic  en1, en2, en3;
  lzd_t  d1;
  hdr_t  d2;
  res_t  d3;

  assign en3 = !v3 || !out_stall_i;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall_o = !en1;

  eoe_lzd u_lzd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (in_valid_i),
    .value_i (value_i),
    .valid_o (v1),
    .data_o  (d1)
  );

  eoe_hdr u_hdr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (d1),
    .valid_o (v2),
    .data_o  (d2)
  );

  eoe_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (d2),
    .valid_o (v3),
    .data_o  (d3)
  );

  assign out_valid_o   = v3;
  assign codeword_o    = d3.codeword;
  assign code_length_o = d3.code_length;

  // Input backpressure only ever comes from an output stall.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_length_o != '0))
    else $error("zero code length");

  a_terminator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !codeword_o[0])
    else $error("terminator bit not zero");

  a_upper_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((codeword_o >> code_length_o) == '0))
    else $error("bits above code length set");

  a_full_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1 && v2 && v3 && out_stall_i) |-> in_stall_o)
    else $error("full pipeline accepted input under stall");

endmodule

FILE: src/eoe_lzd.sv
`timescale 1ns / 1ps

module eoe_lzd (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [eoe_pkg::IN_W-1:0]  value_i,
  output logic                      valid_o,
  output eoe_pkg::lzd_t             data_o
);
  import eoe_pkg::*;

  logic [VAL_W-1:0] val;
  logic [NB_W-1:0]  nb;
  logic             valid_q;
  lzd_t             data_q;

  always_comb begin
    val = value_i[VAL_W-1:0];
    nb  = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (val[i]) nb = NB_W'(i + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q.value <= val;
      data_q.nb    <= nb;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/eoe_hdr.sv
`timescale 1ns / 1ps

module eoe_hdr (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  eoe_pkg::lzd_t data_i,
  output logic          valid_o,
  output eoe_pkg::hdr_t data_o
);
  import eoe_pkg::*;

  function automatic logic [NB_W-1:0] bit_len(input logic [NB_W-1:0] x);
    logic [NB_W-1:0] r;
    r = '0;
    for (int i = 0; i < NB_W; i++) begin
      if (x[i]) r = NB_W'(i + 1);
    end
    return r;
  endfunction

  hdr_t            hdr;
  logic [NB_W-1:0] n;
  logic [NB_W-1:0] bl;
  logic [OFF_W-1:0] off;
  logic            act;
  logic            valid_q;
  hdr_t            data_q;

  // Walk the header chain: each header is the bit length of the previous minus one.
  always_comb begin
    hdr.value = data_i.value;
    hdr.big   = (data_i.nb > NB_W'(1));
    n         = data_i.nb - NB_W'(1);
    off       = OFF_W'(1) + OFF_W'(data_i.nb);
    act       = hdr.big;
    bl        = '0;
    for (int k = 0; k < NUM_SMALL; k++) begin
      bl          = bit_len(n);
      hdr.suse[k] = act && (n > NB_W'(1));
      hdr.sval[k] = n;
      hdr.soff[k] = off;
      if (hdr.suse[k]) begin
        off = off + OFF_W'(bl);
        n   = bl - NB_W'(1);
      end
      act = hdr.suse[k];
    end
    hdr.total = hdr.big ? off : OFF_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= hdr;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/eoe_pack.sv
`timescale 1ns / 1ps

module eoe_pack (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  eoe_pkg::hdr_t data_i,
  output logic          valid_o,
  output eoe_pkg::res_t data_o
);
  import eoe_pkg::*;

  res_t res;
  logic valid_q;
  res_t data_q;

  // Place the value above the terminator, then each header above the last.
  always_comb begin
    res.codeword = '0;
    if (data_i.big) begin
      res.codeword = CODE_W'(data_i.value) << 1;
      for (int k = 0; k < NUM_SMALL; k++) begin
        if (data_i.suse[k]) begin
          res.codeword = res.codeword | (CODE_W'(data_i.sval[k]) << data_i.soff[k]);
        end
      end
    end
    res.code_length = LEN_W'(data_i.total);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= res;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: dv/tb_elias_omega_encoder.sv
`timescale 1ns / 1ps

module tb_elias_omega_encoder;

  import eoe_pkg::*;

  typedef struct {
    logic [CODE_W-1:0] codeword;
    logic [LEN_W-1:0]  code_length;
  } omega_code_t;

  // A row with known set carries its code typed in; other rows go through the predictor.
  typedef struct {
    logic [IN_W-1:0]   value;
    bit                known;
    logic [CODE_W-1:0] codeword;
    logic [LEN_W-1:0]  code_length;
  } dir_row_t;

  localparam int NUM_DIR    = 18;
  localparam int NUM_RANDOM = 400;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [IN_W-1:0]   value_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CODE_W-1:0] codeword_o;
  logic [LEN_W-1:0]  code_length_o;

  logic quiet_q = 1'b0;

  omega_code_t pending_codes[$];
  int          mismatch_count = 0;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{32'h0000_0000, 1'b1, 43'd0,              6'd1},
    '{32'h0000_0001, 1'b1, 43'd0,              6'd1},
    '{32'h0000_0002, 1'b1, 43'd4,              6'd3},
    '{32'h0000_0003, 1'b1, 43'd6,              6'd3},
    '{32'h0000_0004, 1'b1, 43'd40,             6'd6},
    '{32'hFFFF_FFFF, 1'b1, 43'h53F_FFFF_FFFE,  6'd43},
    '{32'h0000_0007, 1'b0, '0, '0},
    '{32'h0000_0008, 1'b0, '0, '0},
    '{32'h0000_000F, 1'b0, '0, '0},
    '{32'h0000_0010, 1'b0, '0, '0},
    '{32'h0000_00FF, 1'b0, '0, '0},
    '{32'h0000_0100, 1'b0, '0, '0},
    '{32'h0000_FFFF, 1'b0, '0, '0},
    '{32'h0001_0000, 1'b0, '0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0, '0},
    '{32'h8000_0000, 1'b0, '0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0, '0},
    '{32'h5555_5555, 1'b0, '0, '0}
  };

  elias_omega_encoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .codeword_o   (codeword_o),
    .code_length_o(code_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Build the code from the tail: terminator first, then each binary group in front.
  function automatic omega_code_t omega_encode(input logic [IN_W-1:0] val);
    logic [63:0]  n;
    logic [63:0]  bits;
    int unsigned  len;
    int unsigned  nb;
    omega_code_t  res;
    n    = 64'(val);
    if (VALUE_BITS < 64) n &= (64'd1 << VALUE_BITS) - 64'd1;
    bits = '0;
    len  = 1;
    while (n > 64'd1) begin
      nb = 0;
      for (int i = 0; i < 64; i++) if (n[i]) nb = i + 1;
      if (len < 64) bits |= n << len;
      len += nb;
      n = 64'(nb - 1);
    end
    res.codeword    = bits[CODE_W-1:0];
    res.code_length = len[LEN_W-1:0];
    return res;
  endfunction

  task automatic send_value(input logic [IN_W-1:0] val, input omega_code_t code);
    while (!quiet_q && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_codes = {pending_codes, code};
  endtask

  initial begin : drive_values
    logic [IN_W-1:0] val;
    int              w;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIR; r++) begin
      if (dir_rows[r].known)
        send_value(dir_rows[r].value, '{dir_rows[r].codeword, dir_rows[r].code_length});
      else
        send_value(dir_rows[r].value, omega_encode(dir_rows[r].value));
    end

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == 150) quiet_q <= 1'b1;
      if (k == 230) quiet_q <= 1'b0;
      val = $urandom;
      // mostly pick a bit length first so every code length shows up
      if ($urandom_range(3) != 0) begin
        w = $urandom_range(IN_W, 0);
        if (w == 0) val = '0;
        else begin
          if (w < IN_W) val &= (32'd1 << w) - 32'd1;
          val[w-1] = 1'b1;
        end
      end
      send_value(val, omega_encode(val));
    end
    in_valid_i <= 1'b0;

    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin : check_codes
    omega_code_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_codes.size() == 0) begin
        $error("codeword %h with no value pending", codeword_o);
        mismatch_count++;
      end else begin
        want = pending_codes.pop_front();
        if (codeword_o !== want.codeword) begin
          $error("codeword: expected %h, got %h", want.codeword, codeword_o);
          mismatch_count++;
        end
        if (code_length_o !== want.code_length) begin
          $error("code_length: expected %0d, got %0d", want.code_length, code_length_o);
          mismatch_count++;
        end
      end
    end
    out_stall_i <= !quiet_q && ($urandom_range(99) < 30);
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
